// ----- design/lvfr_pkg.sv -----
`default_nettype none
package lvfr_pkg;

   localparam int COUNT_BITS = 16;
   localparam int MIN_COUNT  = 65;
   localparam int SQ_W       = 2 * COUNT_BITS;
   localparam int SCALE_W    = 11;
   localparam int WORK_W     = SQ_W + SCALE_W;
   localparam int VALUE_W    = 31;
   localparam int BIN_W      = 27;
   localparam int DIGITS     = 8;
   localparam int BCD_W      = 4 * DIGITS;
   localparam int MOD_STEPS  = 5;

   localparam logic [SCALE_W-1:0] SCALE_L   = SCALE_W'(1000);
   localparam logic [SCALE_W-1:0] SCALE_C   = SCALE_W'(2000);
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
   localparam logic [VALUE_W-1:0] DECADE    = VALUE_W'(100000000);
   localparam logic [COUNT_BITS-1:0] REF_RESET = COUNT_BITS'(65535);

   typedef enum logic {
      OP_INDUCTANCE  = 1'b0,
      OP_CAPACITANCE = 1'b1
   } lvfr_op_type;

   typedef struct packed {
      lvfr_op_type           op;
      logic [COUNT_BITS-1:0] meas;
      logic [SQ_W-1:0]       sq;
   } lvfr_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } lvfr_qstat_type;

   typedef struct packed {
      lvfr_op_type           op;
      logic [COUNT_BITS-1:0] meas;
      logic [COUNT_BITS-1:0] rem;
      logic [WORK_W-1:0]     acc;
      logic [VALUE_W-1:0]    value;
      logic                  ovf;
      logic [VALUE_W-1:0]    res;
      logic [BCD_W-1:0]      bcd;
   } lvfr_stage_type;

   // one restoring division step, quotient bits shift into acc
   function automatic lvfr_stage_type div_step(lvfr_stage_type s);
      lvfr_stage_type        o;
      logic [COUNT_BITS:0]   cand;
      logic [COUNT_BITS:0]   diff;
      logic                  qbit;
      o    = s;
      cand = {s.rem, s.acc[WORK_W-1]};
      diff = cand - {1'b0, s.meas};
      qbit = (cand >= {1'b0, s.meas});
      o.rem = qbit ? diff[COUNT_BITS-1:0] : cand[COUNT_BITS-1:0];
      o.acc = {s.acc[WORK_W-2:0], qbit};
      return o;
   endfunction

   // one double-dabble step: adjust digits, then shift one binary bit in
   function automatic lvfr_stage_type dabble_step(lvfr_stage_type s);
      lvfr_stage_type   o;
      logic [BCD_W-1:0] b;
      o = s;
      b = s.bcd;
      for (int k = 0; k < DIGITS; k++) begin
         if (b[4*k +: 4] >= 4'd5) begin
            b[4*k +: 4] = b[4*k +: 4] + 4'd3;
         end
      end
      o.bcd = {b[BCD_W-2:0], s.res[BIN_W-1]};
      o.res = {s.res[VALUE_W-2:0], 1'b0};
      return o;
   endfunction

endpackage
`default_nettype wire

// ----- design/lvfr_front.sv -----
`default_nettype none
module lvfr_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire lvfr_pkg::lvfr_op_type           in_op,
   input  wire logic [lvfr_pkg::COUNT_BITS-1:0] in_meas,
   input  wire logic [lvfr_pkg::COUNT_BITS-1:0] ref_count,
   input  wire lvfr_pkg::lvfr_qstat_type        qstat,
   output logic                                 push,
   output lvfr_pkg::lvfr_entry_type             push_entry
);

   logic                     valid_ff, valid_in;
   lvfr_pkg::lvfr_entry_type entry_ff, entry_in;
   logic [lvfr_pkg::COUNT_BITS-1:0] clamped;

   assign push     = valid_ff && !qstat.full;
   assign in_ready = !valid_ff || !qstat.full;

   always_comb begin
      clamped = (in_meas > ref_count) ? ref_count : in_meas;
      if (clamped < lvfr_pkg::COUNT_BITS'(lvfr_pkg::MIN_COUNT)) begin
         clamped = lvfr_pkg::COUNT_BITS'(lvfr_pkg::MIN_COUNT);
      end
      entry_in = entry_ff;
      if (in_valid && in_ready) begin
         entry_in.op   = in_op;
         entry_in.meas = clamped;
         entry_in.sq   = lvfr_pkg::SQ_W'(ref_count) * lvfr_pkg::SQ_W'(ref_count);
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign push_entry = entry_ff;

endmodule
`default_nettype wire

// ----- design/lvfr_queue.sv -----
`default_nettype none
module lvfr_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire lvfr_pkg::lvfr_entry_type push_entry,
   input  wire logic                     pop,
   output lvfr_pkg::lvfr_entry_type      head,
   output lvfr_pkg::lvfr_qstat_type      qstat
);

   lvfr_pkg::lvfr_entry_type slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_in    = push ? !wr_ff : wr_ff;
      rd_in    = pop ? !rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   assign head        = slot_ff[rd_ff];
   assign qstat.full  = count_ff[1];
   assign qstat.empty = (count_ff == 2'd0);

endmodule
`default_nettype wire

// ----- design/lvfr_back.sv -----
`default_nettype none
module lvfr_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lvfr_pkg::lvfr_entry_type head,
   input  wire lvfr_pkg::lvfr_qstat_type qstat,
   output logic                          pop,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output lvfr_pkg::lvfr_stage_type      out_stage
);

   localparam int MUL_IX = lvfr_pkg::WORK_W;
   localparam int FIN_IX = 2 * lvfr_pkg::WORK_W + 1;
   localparam int DAB_IX = FIN_IX + lvfr_pkg::MOD_STEPS + 1;
   localparam int STAGES = DAB_IX + lvfr_pkg::BIN_W;

   lvfr_pkg::lvfr_stage_type st_ff [STAGES];
   lvfr_pkg::lvfr_stage_type st_in [STAGES];
   logic [STAGES-1:0]        valid_ff;
   lvfr_pkg::lvfr_stage_type hs;
   logic                     advance;

   assign advance = !valid_ff[STAGES-1] || out_ready;
   assign pop     = advance && !qstat.empty;

   always_comb begin
      hs       = '0;
      hs.op    = head.op;
      hs.meas  = head.meas;
      hs.acc   = lvfr_pkg::WORK_W'(head.sq);
   end

   always_comb begin
      lvfr_pkg::lvfr_stage_type prev;
      lvfr_pkg::lvfr_stage_type cur;
      logic [lvfr_pkg::WORK_W-1:0]  sc;
      logic [lvfr_pkg::WORK_W-1:0]  diff;
      logic [lvfr_pkg::VALUE_W-1:0] m;
      for (int i = 0; i < STAGES; i++) begin
         prev = (i == 0) ? hs : st_ff[(i == 0) ? 0 : i - 1];
         cur  = prev;
         sc   = (prev.op == lvfr_pkg::OP_CAPACITANCE) ?
                lvfr_pkg::WORK_W'(lvfr_pkg::SCALE_C) : lvfr_pkg::WORK_W'(lvfr_pkg::SCALE_L);
         diff = prev.acc - sc;
         m    = '0;
         if (i < MUL_IX) begin
            cur = lvfr_pkg::div_step(prev);
         end else if (i == MUL_IX) begin
            // first quotient never exceeds the square of the reference
            cur.acc = prev.acc[lvfr_pkg::SQ_W-1:0] * sc[lvfr_pkg::SCALE_W-1:0];
            cur.rem = '0;
         end else if (i < FIN_IX) begin
            cur = lvfr_pkg::div_step(prev);
         end else if (i == FIN_IX) begin
            cur.bcd = '0;
            if (prev.acc < sc) begin
               cur.value = '0;
               cur.ovf   = 1'b0;
            end else if (diff > lvfr_pkg::WORK_W'(lvfr_pkg::VALUE_MAX)) begin
               cur.value = lvfr_pkg::VALUE_MAX;
               cur.ovf   = 1'b1;
            end else begin
               cur.value = diff[lvfr_pkg::VALUE_W-1:0];
               cur.ovf   = 1'b0;
            end
            cur.res = cur.value;
         end else if (i < DAB_IX) begin
            m = lvfr_pkg::DECADE << (lvfr_pkg::MOD_STEPS - 1 - (i - FIN_IX - 1));
            if (prev.res >= m) begin
               cur.res = prev.res - m;
            end
         end else begin
            cur = lvfr_pkg::dabble_step(prev);
         end
         st_in[i] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STAGES-2:0], pop};
      end
      if (advance) begin
         for (int i = 0; i < STAGES; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_stage = st_ff[STAGES-1];

endmodule
`default_nettype wire

// ----- design/lc_value_from_frequency_ratio_unit.sv -----
`default_nettype none
// lc meter value unit: each req transaction carries a mode (0 inductance in 0.1 uH,
// 1 capacitance in pF) and a measured oscillator count; the rsp transaction returns
// ((ref*ref/meas)*scale/meas)-scale, saturated to 31 bits with an overflow flag, plus
// eight packed bcd digits of the value mod 10^8. the reference count is written
// through csr_write_enable/csr_write_data (reset 65535); the user must write it only
// while the unit is idle, and the block itself does not enforce this. one transaction
// is accepted per cycle, sustained, while rsp_ready stays high. the arithmetic runs
// through the two bit-per-stage divider pipelines and the bit-per-stage binary to
// bcd pipeline. a two-entry queue sits between the front stage and the arithmetic
// pipeline.
module lc_value_from_frequency_ratio_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [lvfr_pkg::COUNT_BITS-1:0] csr_write_data,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_op,
   input  wire logic [lvfr_pkg::COUNT_BITS-1:0] req_measured_count,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_mode_echo,
   output logic [lvfr_pkg::VALUE_W-1:0]         rsp_value,
   output logic [lvfr_pkg::BCD_W-1:0]           rsp_bcd_digits,
   output logic                                 rsp_overflow
);

   // reference count register
   logic [lvfr_pkg::COUNT_BITS-1:0] ref_ff, ref_in;

   lvfr_pkg::lvfr_qstat_type qstat;
   lvfr_pkg::lvfr_entry_type push_entry, head;
   lvfr_pkg::lvfr_stage_type out_stage;
   logic                     push, pop;

   assign ref_in = csr_write_enable ? csr_write_data : ref_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= lvfr_pkg::REF_RESET;
      end else begin
         ref_ff <= ref_in;
      end
   end

   // front: clamp the count and square the reference
   lvfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_op      (lvfr_pkg::lvfr_op_type'(req_op)),
      .in_meas    (req_measured_count),
      .ref_count  (ref_ff),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   // decoupling queue
   lvfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   // back: dividers, scaling, saturation, mod and bcd conversion
   lvfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_stage (out_stage)
   );

   assign rsp_mode_echo  = out_stage.op;
   assign rsp_value      = out_stage.value;
   assign rsp_bcd_digits = out_stage.bcd;
   assign rsp_overflow   = out_stage.ovf;

   // saturated results carry the full-scale value
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_value == lvfr_pkg::VALUE_MAX)
      else $error("overflow without saturated value");

   // every bcd digit is decimal
   a_bcd_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bcd_digits[3:0] <= 4'd9 && rsp_bcd_digits[7:4] <= 4'd9 &&
         rsp_bcd_digits[11:8] <= 4'd9 && rsp_bcd_digits[15:12] <= 4'd9 &&
         rsp_bcd_digits[19:16] <= 4'd9 && rsp_bcd_digits[23:20] <= 4'd9 &&
         rsp_bcd_digits[27:24] <= 4'd9 && rsp_bcd_digits[31:28] <= 4'd9)
      else $error("bcd digit out of range");

   // the queue is never pushed while full nor popped while empty
   a_queue_flow: assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full) && !(pop && qstat.empty))
      else $error("queue flow violation");

endmodule
`default_nettype wire

// ----- bench/lc_value_from_frequency_ratio_unit_tb.sv -----
`default_nettype none
module lc_value_from_frequency_ratio_unit_tb;
   import lvfr_pkg::*;

   localparam int LATENCY   = 122;
   localparam int WDOG_MAX  = 4000;
   localparam int N_RANDOM  = 800;

   // one predicted rsp transaction
   typedef struct {
      logic                  mode;
      logic [VALUE_W-1:0]    value;
      logic [BCD_W-1:0]      bcd;
      logic                  ovf;
   } lc_result_t;

   // directed row: op, count, and an optional typed-in expectation
   typedef struct {
      lvfr_op_type           op;
      logic [COUNT_BITS-1:0] meas;
      bit                    fixed;
      logic [VALUE_W-1:0]    value;
      logic                  ovf;
   } lc_row_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [COUNT_BITS-1:0]  csr_write_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_op = 1'b0;
   logic [COUNT_BITS-1:0]  req_measured_count = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_mode_echo;
   logic [VALUE_W-1:0]     rsp_value;
   logic [BCD_W-1:0]       rsp_bcd_digits;
   logic                   rsp_overflow;

   // testbench copy of the reference count register
   logic [COUNT_BITS-1:0]  ref_count_shadow;
   lc_result_t             pending_results[$];
   int                     fail_count = 0;
   int                     idle_cycles = 0;
   bit                     rx_stall_mode = 0;

   lc_value_from_frequency_ratio_unit dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_measured_count(req_measured_count),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_mode_echo(rsp_mode_echo),
      .rsp_value(rsp_value), .rsp_bcd_digits(rsp_bcd_digits),
      .rsp_overflow(rsp_overflow)
   );

   always #6 clock = ~clock;

   // packed bcd of v mod 10^8, lowest digit in the low nibble
   function automatic logic [BCD_W-1:0] bcd_of(logic [VALUE_W-1:0] v);
      logic [31:0]      r;
      logic [BCD_W-1:0] p;
      r = 32'(v) % 32'd100000000;
      p = '0;
      for (int k = 0; k < DIGITS; k++) begin
         p[4*k +: 4] = 4'(r % 32'd10);
         r = r / 32'd10;
      end
      return p;
   endfunction

   // clamp the count, run both truncating divisions, subtract and saturate
   function automatic lc_result_t lc_value_of(lvfr_op_type op, logic [COUNT_BITS-1:0] meas,
                                             logic [COUNT_BITS-1:0] refc);
      lc_result_t   r;
      logic [63:0]  m;
      logic [63:0]  q;
      logic [63:0]  scale;
      m = 64'(meas);
      scale = (op == OP_CAPACITANCE) ? 64'd2000 : 64'd1000;
      if (m > 64'(refc)) m = 64'(refc);
      if (m < 64'(MIN_COUNT)) m = 64'(MIN_COUNT);
      q = (64'(refc) * 64'(refc)) / m;
      q = (q * scale) / m;
      r.mode = op;
      r.ovf  = 1'b0;
      if (q < scale) begin
         r.value = '0;
      end else begin
         q = q - scale;
         if (q > 64'h7FFFFFFF) begin
            r.value = VALUE_MAX;
            r.ovf   = 1'b1;
         end else begin
            r.value = q[VALUE_W-1:0];
         end
      end
      r.bcd = bcd_of(r.value);
      return r;
   endfunction

   // drive one req transaction at the falling edge, hold until accepted
   task automatic send_req(lvfr_op_type op, logic [COUNT_BITS-1:0] meas);
      req_valid          <= 1'b1;
      req_op             <= op;
      req_measured_count <= meas;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(lc_value_of(op, meas, ref_count_shadow));
      @(negedge clock);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   // wait until every expected result is in, then let the pipe drain
   task automatic drain();
      drop_valid();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);
   endtask

   // register writes happen only while idle
   task automatic write_ref(logic [COUNT_BITS-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      ref_count_shadow = v;
      @(negedge clock);
   endtask

   // receiver: alternate between random stalls and a long always-ready stretch
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) rx_stall_mode = ~rx_stall_mode;
      rsp_ready <= rx_stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
   end

   // check each rsp transaction against the oldest expectation
   always @(posedge clock) begin
      lc_result_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected rsp transaction value=%0d", $time, rsp_value);
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_mode_echo !== e.mode) begin
               $display("%0t: mode_echo expected %0d actual %0d", $time, e.mode, rsp_mode_echo);
               fail_count++;
            end
            if (rsp_value !== e.value) begin
               $display("%0t: value expected %0d actual %0d", $time, e.value, rsp_value);
               fail_count++;
            end
            if (rsp_bcd_digits !== e.bcd) begin
               $display("%0t: bcd_digits expected %h actual %h", $time, e.bcd, rsp_bcd_digits);
               fail_count++;
            end
            if (rsp_overflow !== e.ovf) begin
               $display("%0t: overflow expected %0d actual %0d", $time, e.ovf, rsp_overflow);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (pending_results.size() != 0 || req_valid) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_MAX) begin
            $display("Test completed with failures");
            $finish;
         end
      end else begin
         idle_cycles <= 0;
      end
   end

   lc_row_t rows[$];
   lc_result_t pr;

   initial begin
      int burst;
      logic [COUNT_BITS-1:0] refs[6];
      logic [COUNT_BITS-1:0] m;
      lvfr_op_type o;
      ref_count_shadow = REF_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows at the reset reference of 65535
      rows.push_back('{OP_INDUCTANCE,  16'hFFFF, 1, 31'd0, 1'b0});   // no unknown part
      rows.push_back('{OP_CAPACITANCE, 16'hFFFF, 1, 31'd0, 1'b0});
      rows.push_back('{OP_INDUCTANCE,  16'd0,    1, 31'd1016528276, 1'b0}); // clamp up
      rows.push_back('{OP_CAPACITANCE, 16'd65,   1, 31'd2033056553, 1'b0}); // largest value
      rows.push_back('{OP_INDUCTANCE,  16'd64,   1, 31'd1016528276, 1'b0});
      rows.push_back('{OP_INDUCTANCE,  16'd32768, 0, '0, 0});
      rows.push_back('{OP_CAPACITANCE, 16'd32768, 0, '0, 0});
      rows.push_back('{OP_INDUCTANCE,  16'd1000, 0, '0, 0});
      rows.push_back('{OP_CAPACITANCE, 16'd5000, 0, '0, 0});
      rows.push_back('{OP_INDUCTANCE,  16'hFFFE, 0, '0, 0});
      rows.push_back('{OP_CAPACITANCE, 16'h5555, 0, '0, 0});
      rows.push_back('{OP_INDUCTANCE,  16'hAAAA, 0, '0, 0});
      foreach (rows[i]) begin
         send_req(rows[i].op, rows[i].meas);
         if (rows[i].fixed) begin
            pr = pending_results.pop_back();
            pr.value = rows[i].value;
            pr.ovf   = rows[i].ovf;
            pr.bcd   = bcd_of(rows[i].value);
            pending_results.push_back(pr);
         end
      end
      drain();

      // reference below the minimum count: negative difference gives zero
      write_ref(16'd10);
      send_req(OP_INDUCTANCE, 16'd0);
      send_req(OP_CAPACITANCE, 16'd100);
      drain();
      write_ref(16'd65);
      send_req(OP_INDUCTANCE, 16'd65);
      send_req(OP_CAPACITANCE, 16'hFFFF);
      send_req(OP_INDUCTANCE, 16'd0);
      drain();

      // random part over several reference settings, extremes included
      refs = '{16'hFFFF, 16'd65, 16'd0, 16'd40000, 16'd1200, 16'hFFFF};
      for (int p = 0; p < 6; p++) begin
         if (p == 5) refs[p] = COUNT_BITS'($urandom_range(65, 65535));
         write_ref(refs[p]);
         for (int n = 0; n < N_RANDOM / 6; ) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && n < N_RANDOM / 6; b++, n++) begin
               o = lvfr_op_type'($urandom_range(0, 1));
               case ($urandom_range(0, 3))
                  0:       m = COUNT_BITS'($urandom);
                  1:       m = COUNT_BITS'($urandom_range(0, 200));
                  2:       m = refs[p] - COUNT_BITS'($urandom_range(0, 300));
                  default: m = COUNT_BITS'($urandom_range(refs[p] / 2, refs[p]));
               endcase
               send_req(o, m);
            end
            if ($urandom_range(0, 2) != 0) begin
               drop_valid();
               repeat ($urandom_range(1, 12)) @(negedge clock);
            end
         end
         // sender holds off until every expected result has come
         drain();
      end

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
design/lvfr_pkg.sv
design/lvfr_front.sv
design/lvfr_queue.sv
design/lvfr_back.sv
design/lc_value_from_frequency_ratio_unit.sv
bench/lc_value_from_frequency_ratio_unit_tb.sv
